@@ sv/bums_pkg.sv @@
// Shared types for the bottom-up merge sorter.
// No dependencies; the channel interfaces and the top level import it.
package bums_pkg;

    // Command carried by each input beat.
    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_PULL = 1'b1
    } t_kind;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PULL  = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_MERGE = 4'b1000
    } t_state;

endpackage

@@ sv/bums_in_if.sv @@
// Input channel of the merge sorter: push and pull commands.
// Depends on bums_pkg for the command type.
interface bums_in_if
    import bums_pkg::*;
#(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    t_kind                       kind;
    logic signed [WORD_BITS-1:0] value;
    logic                        last;

    modport source (output valid, kind, value, last, input ready);
    modport sink   (input valid, kind, value, last, output ready);
endinterface

@@ sv/bums_out_if.sv @@
// Result channel of the merge sorter: one beat per pull command.
// Imports bums_pkg but uses none of its types.
interface bums_out_if
    import bums_pkg::*;
#(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] sorted_value;
    logic                        final_element;
    logic                        empty_res;

    modport source (output valid, sorted_value, final_element, empty_res, input ready);
    modport sink   (input valid, sorted_value, final_element, empty_res, output ready);
endinterface

@@ sv/bottom_up_merge_sort.sv @@
// Bottom-up merge sorter: top level with two ping-pong word memories.
// Depends on bums_pkg, bums_in_if and bums_out_if.
//
// Usage: i_in carries commands. A push beat (kind = push) loads one signed word;
// the word marked last starts the sort. Words beyond DEPTH are dropped. A pull
// beat returns one beat on o_out: the next word in ascending order, with
// final_element on the last one, or empty_res when nothing is left (or the set
// is not sorted yet). A push after a sorted set discards it and starts anew.
// Flow: a push is taken in idle. The sort holds i_in.ready low until it is
// done, its length set by the single merge unit, which writes one word per
// cycle into the other memory and passes through ST_SETUP once per run pair.
// A pull beat moves to ST_PULL and holds i_in.ready low there; its result is
// loaded into the output register from ST_PULL once that register is free,
// behind the registered memory read.
// Stall: the result sits in an output register; pushes are still taken while
// it waits, and a further pull waits until the register is taken.
// Reset: the set is empty, nothing is sorted, and a pull answers empty. The
// memory contents are not cleared; no clearing pass is needed.
module bottom_up_merge_sort
    import bums_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bums_in_if.sink           i_in,
    bums_out_if.source        o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 2;

    // Two word memories; the set is loaded into r_mem_a, and r_src marks
    // which one holds the current source runs.
    logic [WORD_BITS-1:0] r_mem_a [DEPTH];
    logic [WORD_BITS-1:0] r_mem_b [DEPTH];
    logic [WORD_BITS-1:0] r_qa_a, r_qb_a, r_qa_b, r_qb_b;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_rpos, n_rpos;
    logic           r_sorted, n_sorted;
    logic           r_src, n_src;
    logic [XW-1:0]  r_w, n_w;
    logic [XW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_a, n_a, r_b, n_b, r_k, n_k, r_mid, n_mid, r_end, n_end;

    logic                 r_ovalid, n_ovalid;
    logic [WORD_BITS-1:0] r_oval, n_oval;
    logic                 r_ofinal, n_ofinal;
    logic                 r_oempty, n_oempty;

    logic                 w_in_fire;
    logic [WORD_BITS-1:0] w_da, w_db;
    logic                 w_take_a;
    logic [WORD_BITS-1:0] w_merge_d;
    logic [CW-1:0]        w_base;
    logic [XW-1:0]        w_n, w_rem, w_jw, w_j2w;
    logic                 w_hit;
    logic                 w_we_a, w_we_b;
    logic [AW-1:0]        w_wa_a, w_ra, w_rb;
    logic [WORD_BITS-1:0] w_wd_a;

    assign w_in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    assign w_da = r_src ? r_qa_b : r_qa_a;
    assign w_db = r_src ? r_qb_b : r_qb_a;

    assign w_take_a  = (r_a < r_mid)
                    && ((r_b >= r_end) || ($signed(w_da) <= $signed(w_db)));
    assign w_merge_d = w_take_a ? w_da : w_db;

    assign w_base = r_sorted ? '0 : r_count;
    assign w_n    = XW'(r_count);
    assign w_rem  = w_n - r_j;
    assign w_jw   = r_j + r_w;
    assign w_j2w  = r_j + (r_w << 1);
    assign w_hit  = r_sorted && (r_rpos < r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rpos   = r_rpos;
        n_sorted = r_sorted;
        n_src    = r_src;
        n_w      = r_w;
        n_j      = r_j;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_mid    = r_mid;
        n_end    = r_end;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oval   = r_oval;
        n_ofinal = r_ofinal;
        n_oempty = r_oempty;
        w_we_a   = 1'b0;
        w_we_b   = 1'b0;
        w_wa_a   = r_k[AW-1:0];
        w_wd_a   = w_merge_d;

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_in.kind == KIND_PULL) begin
                        n_state = ST_PULL;
                    end else begin
                        n_src = 1'b0;
                        if (r_sorted) begin
                            n_sorted = 1'b0;
                            n_rpos   = '0;
                            n_count  = '0;
                        end
                        if (w_base < CW'(DEPTH)) begin
                            w_we_a  = 1'b1;
                            w_wa_a  = w_base[AW-1:0];
                            w_wd_a  = i_in.value;
                            n_count = w_base + CW'(1);
                        end
                        if (i_in.last) begin
                            n_w     = XW'(1);
                            n_j     = '0;
                            n_state = ST_SETUP;
                        end
                    end
                end
            end
            ST_PULL: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = w_hit ? w_da : '0;
                    n_ofinal = w_hit && ((r_rpos + CW'(1)) == r_count);
                    n_oempty = !w_hit;
                    if (w_hit) begin
                        n_rpos = r_rpos + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_SETUP: begin
                if (r_w >= w_n) begin
                    n_sorted = 1'b1;
                    n_rpos   = '0;
                    n_state  = ST_IDLE;
                end else if (r_j >= w_n) begin
                    // End of a pass: double the run width and swap roles.
                    n_w   = r_w << 1;
                    n_j   = '0;
                    n_src = !r_src;
                end else begin
                    // Runs that reach past the end are clamped to the count.
                    n_mid   = (w_rem > r_w) ? w_jw[CW-1:0] : r_count;
                    n_end   = (w_rem > (r_w << 1)) ? w_j2w[CW-1:0] : r_count;
                    n_a     = r_j[CW-1:0];
                    n_k     = r_j[CW-1:0];
                    n_b     = n_mid;
                    n_j     = w_j2w;
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                w_we_a = r_src;
                w_we_b = !r_src;
                if (w_take_a) begin
                    n_a = r_a + CW'(1);
                end else begin
                    n_b = r_b + CW'(1);
                end
                n_k = r_k + CW'(1);
                if (n_k == r_end) begin
                    n_state = ST_SETUP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Reads run ahead on the next pointers so data lines up with the merge step.
    assign w_ra = ((r_state == ST_IDLE) || (r_state == ST_PULL)) ? r_rpos[AW-1:0]
                                                                   : n_a[AW-1:0];
    assign w_rb = n_b[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[w_wa_a] <= w_wd_a;
        end
        r_qa_a <= r_mem_a[w_ra];
        r_qb_a <= r_mem_a[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[r_k[AW-1:0]] <= w_merge_d;
        end
        r_qa_b <= r_mem_b[w_ra];
        r_qb_b <= r_mem_b[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rpos   <= '0;
            r_sorted <= 1'b0;
            r_src    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rpos   <= n_rpos;
            r_sorted <= n_sorted;
            r_src    <= n_src;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_j      <= n_j;
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_mid    <= n_mid;
        r_end    <= n_end;
        r_oval   <= n_oval;
        r_ofinal <= n_ofinal;
        r_oempty <= n_oempty;
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.sorted_value  = r_oval;
    assign o_out.final_element = r_ofinal;
    assign o_out.empty_res     = r_oempty;

`ifndef SYNTHESIS
    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_k < r_end) && (r_a <= r_mid) && (r_b <= r_end))
        else $error("merge pointers out of run bounds");

    // Every word written so far came from one of the two run heads.
    a_merge_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> ((r_a + r_b) == (r_k + r_mid)))
        else $error("merge output index lost track of run heads");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)) && (r_rpos <= r_count))
        else $error("element count or read position out of range");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oempty) |-> (r_oval == '0) && !r_ofinal)
        else $error("empty result carries a word or final flag");

    a_sort_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && w_in_fire && (i_in.kind == KIND_PUSH) && i_in.last)
        |=> (r_state == ST_SETUP) && !r_sorted)
        else $error("last push did not start the sort");
`endif

endmodule

@@ tb/sv/bums_sort_checker.sv @@
`timescale 1ns / 100ps
// Checker for the merge sorter: watches the command and result channels, keeps
// its own copy of the loaded set and compares every result beat in order.
// Depends on bums_pkg, bums_in_if and bums_out_if.
module bums_sort_checker
    import bums_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bums_in_if   i_cmd,
    bums_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct {
        t_word word;
        logic  final_flag;
        logic  empty_flag;
    } t_pull_answer;

    t_word        set_words   [DEPTH];
    t_word        merge_words [DEPTH];
    int unsigned  words_held  = 0;
    int unsigned  next_read   = 0;
    bit           set_sorted  = 1'b0;
    t_pull_answer answers_due [$];
    int           fail_total  = 0;
    int           pending_total = 0;
    int           result_beats  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    always @(posedge i_clk) begin : watch
        t_pull_answer due;
        int unsigned  n, width, base, mid, stop, a, b, k;

        if (i_rst_n && i_cmd.valid && i_cmd.ready) begin
            if (i_cmd.kind == KIND_PUSH) begin
                // A push after a finished sort throws the old set away.
                if (set_sorted) begin
                    set_sorted = 1'b0;
                    words_held = 0;
                    next_read  = 0;
                end
                if (words_held < DEPTH) begin
                    set_words[words_held] = i_cmd.value;
                    words_held++;
                end
                if (i_cmd.last) begin
                    // Bottom-up passes; a trailing left run that reaches past the
                    // end is cut short and merged with an empty right run.
                    n = words_held;
                    for (width = 1; width < n; width = width * 2) begin
                        for (base = 0; base < n; base = base + 2 * width) begin
                            mid  = (n - base > width) ? base + width : n;
                            stop = (n - base > 2 * width) ? base + 2 * width : n;
                            a = base;
                            b = mid;
                            for (k = base; k < stop; k++) begin
                                if (b >= stop || (a < mid && set_words[a] <= set_words[b])) begin
                                    merge_words[k] = set_words[a];
                                    a++;
                                end else begin
                                    merge_words[k] = set_words[b];
                                    b++;
                                end
                            end
                        end
                        for (k = 0; k < n; k++)
                            set_words[k] = merge_words[k];
                    end
                    next_read  = 0;
                    set_sorted = 1'b1;
                end
            end else begin
                if (set_sorted && next_read < words_held) begin
                    due.word       = set_words[next_read];
                    due.final_flag = (next_read + 1 == words_held);
                    due.empty_flag = 1'b0;
                    next_read++;
                end else begin
                    due.word       = '0;
                    due.final_flag = 1'b0;
                    due.empty_flag = 1'b1;
                end
                answers_due.push_back(due);
            end
        end

        if (i_rst_n && i_res.valid && i_res.ready) begin
            result_beats++;
            if (answers_due.size() == 0) begin
                fail_total++;
                if (fail_total <= 10)
                    $display("result beat %0d with no pull waiting: value %0d final %0b empty %0b",
                             result_beats, i_res.sorted_value, i_res.final_element,
                             i_res.empty_res);
            end else begin
                due = answers_due.pop_front();
                if (i_res.sorted_value !== due.word || i_res.final_element !== due.final_flag
                        || i_res.empty_res !== due.empty_flag) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display({"result beat %0d: expected value %0d final %0b empty %0b, ",
                                  "got value %0d final %0b empty %0b"},
                                 result_beats, due.word, due.final_flag, due.empty_flag,
                                 i_res.sorted_value, i_res.final_element, i_res.empty_res);
                end
            end
        end

        pending_total = answers_due.size();
    end

endmodule

@@ tb/sv/bottom_up_merge_sort_tb.sv @@
`timescale 1ns / 100ps
// Top of the merge sorter testbench: clock, reset, command stimulus and result
// back-pressure. Depends on bums_pkg, both channel interfaces and bums_sort_checker.
module bottom_up_merge_sort_tb;
    import bums_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int WORD_BITS   = 32;
    localparam int BEAT_TARGET = 1650;
    localparam int PHASE_BEATS = 150;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   answers_pending;
    int   beats_sent   = 0;
    int   send_gap_pct = 0;
    int   stall_pct    = 0;

    bums_in_if  #(.WORD_BITS(WORD_BITS)) cmd_if ();
    bums_out_if #(.WORD_BITS(WORD_BITS)) res_if ();

    bottom_up_merge_sort #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    bums_sort_checker #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (answers_pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Words for one set: full random, a narrow band full of ties, or extremes.
    function automatic t_word pick_word(input int fill);
        t_word word;
        case (fill)
            0: word = $urandom;
            1: word = int'($urandom_range(8)) - 4;
            default: begin
                case ($urandom_range(4))
                    0: word = WORD_MIN;
                    1: word = WORD_MAX;
                    2: word = '0;
                    3: word = '1;
                    default: word = 1;
                endcase
            end
        endcase
        return word;
    endfunction

    // Presents one command beat and returns once it is accepted.
    task automatic send_cmd(input t_kind kind, input t_word word, input logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.kind  <= kind;
        cmd_if.value <= word;
        cmd_if.last  <= is_last;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        beats_sent++;
        case ((beats_sent / PHASE_BEATS) % 4)
            0: begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            1: begin
                send_gap_pct = 49;
                stall_pct    = 0;
            end
            2: begin
                send_gap_pct = 0;
                stall_pct    = 49;
            end
            default: begin
                send_gap_pct = 28;
                stall_pct    = 28;
            end
        endcase
    endtask

    initial begin
        int unsigned set_size, held, pull_total, i;
        int          fill, sel;

        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.kind  <= KIND_PUSH;
        cmd_if.value <= '0;
        cmd_if.last  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pull with nothing loaded, then a set of extremes with a repeated
        // minimum and a length that leaves a short trailing run.
        send_cmd(KIND_PULL, WORD_MAX, 1'b1);
        send_cmd(KIND_PUSH, WORD_MAX, 1'b0);
        send_cmd(KIND_PUSH, WORD_MIN, 1'b0);
        send_cmd(KIND_PUSH, '0, 1'b0);
        send_cmd(KIND_PUSH, '1, 1'b0);
        send_cmd(KIND_PUSH, 1, 1'b0);
        send_cmd(KIND_PUSH, WORD_MIN, 1'b1);
        repeat (7) send_cmd(KIND_PULL, '0, 1'b0);
        // One-word set, read past its end.
        send_cmd(KIND_PUSH, 5, 1'b1);
        repeat (2) send_cmd(KIND_PULL, '1, 1'b0);
        // Pull while a set is still loading, then a new set over a half-read one.
        send_cmd(KIND_PUSH, 9, 1'b0);
        send_cmd(KIND_PULL, '0, 1'b0);
        send_cmd(KIND_PUSH, -9, 1'b1);
        send_cmd(KIND_PULL, '0, 1'b0);
        send_cmd(KIND_PUSH, 3, 1'b1);
        send_cmd(KIND_PULL, '0, 1'b1);

        // A set that overruns the store: the words past the depth are dropped,
        // the marked one too, and only the head of the sorted set is read.
        for (i = 0; i < DEPTH + 2; i++)
            send_cmd(KIND_PUSH, pick_word(0), i == DEPTH + 1);
        repeat (12) send_cmd(KIND_PULL, '0, 1'b0);

        while (beats_sent < BEAT_TARGET) begin
            if ($urandom_range(99) < 85) begin
                sel = $urandom_range(99);
                if (sel < 70)
                    set_size = $urandom_range(12, 1);
                else if (sel < 95)
                    set_size = $urandom_range(48, 13);
                else
                    set_size = $urandom_range(96, 49);
                fill = $urandom_range(2);
                for (i = 0; i < set_size; i++)
                    send_cmd(KIND_PUSH, pick_word(fill), i == set_size - 1);
                held = (set_size > DEPTH) ? DEPTH : set_size;
                // Now and then the set is only partly read before the next one.
                if ($urandom_range(99) < 15)
                    pull_total = $urandom_range(held - 1);
                else
                    pull_total = held + $urandom_range(2);
                for (i = 0; i < pull_total; i++)
                    send_cmd(KIND_PULL, $urandom, $urandom_range(1));
            end else begin
                repeat ($urandom_range(4, 1))
                    send_cmd(t_kind'($urandom_range(1)), pick_word($urandom_range(2)),
                             $urandom_range(99) < 25);
            end
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (answers_pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && answers_pending == 0)
            $display("bottom_up_merge_sort_tb passed");
        else
            $display("bottom_up_merge_sort_tb failed");
        $finish;
    end

    // Far beyond the slowest correct run, including every sort and every stall.
    initial begin
        #(12 * 1000000);
        $display("bottom_up_merge_sort_tb failed");
        $finish;
    end

endmodule
